// ----- hw/rtl/aced_pkg.sv -----
// ----------------------------------------------------------------------------
// aced_pkg
// Shared types and constants of the escape sequence decoder: character
// codes, configuration register indexes and the result bundle that travels
// from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package aced_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgEchoMode     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgQuoteCtl     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDropUnknown  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgStopOnC      = 2'd3;

  // Character codes.
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChEsc       = 8'h1B;
  localparam logic [7:0] ChQuote     = 8'h01;
  localparam logic [7:0] ChDel       = 8'h7F;
  localparam logic [7:0] CtrlMask    = 8'h1F;
  localparam logic [7:0] ByteMask    = 8'hFF;

  // Depth of the bundle queue between front and back end.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // Largest number of results one input byte can cause.
  localparam int unsigned MaxResults = 3;

  // One result item before the run and string markers are attached.
  typedef struct packed {
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       stop_seen;
  } item_t;

  // All results caused by one accepted input byte.
  typedef struct packed {
    item_t [MaxResults-1:0] items;
    logic  [1:0]            cnt;
    logic                   last;
  } bundle_t;

endpackage

// ----- hw/rtl/aced_if.sv -----
// ----------------------------------------------------------------------------
// aced_if
// Valid/ready channels of the escape sequence decoder: the source byte
// stream and the expanded result stream.
// ----------------------------------------------------------------------------

// Source string bytes.
interface aced_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_in;

  modport source (output valid, output byte_in, output last_in, input ready);
  modport sink   (input valid, input byte_in, input last_in, output ready);
endinterface

// Expanded result items.
interface aced_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       byte_valid;
  logic       stop_seen;
  logic       run_end;
  logic       last_out;

  modport source (output valid, output byte_out, output byte_valid, output stop_seen,
                  output run_end, output last_out, input ready);
  modport sink   (input valid, input byte_out, input byte_valid, input stop_seen,
                  input run_end, input last_out, output ready);
endinterface

// ----- hw/rtl/aced_front.sv -----
// ----------------------------------------------------------------------------
// aced_front
// Front end: holds the configuration registers and the escape parser state,
// accepts one source byte per cycle while the queue has room and turns it
// into a bundle of up to three result items for the queue.
// ----------------------------------------------------------------------------
module aced_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  aced_in_if.sink                       in_i,
  input  logic                          cfg_we_i,
  input  logic [aced_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic                          cfg_wdata_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output aced_pkg::bundle_t             push_data_o
);

  // Parser phases.
  localparam logic [2:0] PhIdle   = 3'd0;
  localparam logic [2:0] PhEsc    = 3'd1;
  localparam logic [2:0] PhOct    = 3'd2;
  localparam logic [2:0] PhHex0   = 3'd3;
  localparam logic [2:0] PhHex1   = 3'd4;
  localparam logic [2:0] PhBrace  = 3'd5;
  localparam logic [2:0] PhCtrl   = 3'd6;
  localparam logic [2:0] PhCtrlBs = 3'd7;

  localparam int unsigned NumCand = 6;

  logic       echo_q, quote_q, drop_q, stopc_q;
  logic [2:0] phase_q, phase_d;
  logic [7:0] acc_q, acc_d;
  logic [1:0] dig_q, dig_d;
  logic       stop_q, stop_d;

  logic       fire;
  logic [7:0] b;
  logic       lst;
  logic       b_is_oct, b_is_hex;
  logic [3:0] b_hex;
  logic [7:0] oct_acc, hex_acc;

  logic       lit0_en, lit0_v, lit0_s, lit1_en, emit_en, do_idle;
  logic [7:0] lit0_b, lit1_b, emit_b;

  aced_pkg::item_t       cand [NumCand];
  logic [NumCand-1:0]    cand_en;
  aced_pkg::bundle_t     bundle;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  // Letters sit at 0x41/0x61 upward, so the low nibble plus nine gives 10..15.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return (c[6]) ? (c[3:0] + 4'd9) : c[3:0];
  endfunction

  assign fire     = in_i.valid & in_i.ready;
  assign in_i.ready = ~q_full_i;
  assign b        = in_i.byte_in;
  assign lst      = in_i.last_in;
  assign b_is_oct = (b[7:3] == 5'b00110);
  assign b_is_hex = is_hex(b);
  assign b_hex    = hex_val(b);
  assign oct_acc  = {acc_q[4:0], b[2:0]};
  assign hex_acc  = {acc_q[3:0], b_hex};

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_q  <= 1'b0;
      quote_q <= 1'b0;
      drop_q  <= 1'b0;
      stopc_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        aced_pkg::CfgEchoMode:    echo_q  <= cfg_wdata_i;
        aced_pkg::CfgQuoteCtl:    quote_q <= cfg_wdata_i;
        aced_pkg::CfgDropUnknown: drop_q  <= cfg_wdata_i;
        aced_pkg::CfgStopOnC:     stopc_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Escape parser: literal pushes, then one escaped value, then the byte itself.
  always_comb begin
    lit0_en = 1'b0;
    lit0_b  = '0;
    lit0_v  = 1'b1;
    lit0_s  = 1'b0;
    lit1_en = 1'b0;
    lit1_b  = '0;
    emit_en = 1'b0;
    emit_b  = '0;
    do_idle = 1'b0;
    phase_d = phase_q;
    acc_d   = acc_q;
    dig_d   = dig_q;
    stop_d  = stop_q;

    if (stop_q) begin
      // After a stop only the final byte reports, with another marker.
      if (lst) begin
        lit0_en = 1'b1;
        lit0_v  = 1'b0;
        lit0_s  = 1'b1;
      end
    end else begin
      unique case (phase_q)
        PhEsc: begin
          phase_d = PhIdle;
          unique case (b) inside
            8'h61: begin emit_en = 1'b1; emit_b = 8'h07; end        // a
            8'h76: begin emit_en = 1'b1; emit_b = 8'h0B; end        // v
            8'h62: begin emit_en = 1'b1; emit_b = 8'h08; end        // b
            8'h65, 8'h45: begin emit_en = 1'b1; emit_b = aced_pkg::ChEsc; end
            8'h66: begin emit_en = 1'b1; emit_b = 8'h0C; end        // f
            8'h6E: begin emit_en = 1'b1; emit_b = 8'h0A; end        // n
            8'h72: begin emit_en = 1'b1; emit_b = 8'h0D; end        // r
            8'h74: begin emit_en = 1'b1; emit_b = 8'h09; end        // t
            [8'h31:8'h37]: begin
              if (echo_q) begin
                lit0_en = 1'b1;
                lit0_b  = aced_pkg::ChBackslash;
                lit1_en = 1'b1;
                lit1_b  = b;
              end else begin
                acc_d   = {5'b0, b[2:0]};
                dig_d   = 2'd2;
                phase_d = PhOct;
                if (lst) begin
                  emit_en = 1'b1;
                  emit_b  = acc_d;
                  phase_d = PhIdle;
                end
              end
            end
            8'h30: begin
              acc_d   = '0;
              dig_d   = echo_q ? 2'd3 : 2'd2;
              phase_d = PhOct;
              if (lst) begin
                emit_en = 1'b1;
                emit_b  = '0;
                phase_d = PhIdle;
              end
            end
            8'h78: begin                                          // x
              if (lst) begin
                lit0_en = 1'b1;
                lit0_b  = aced_pkg::ChBackslash;
                lit1_en = 1'b1;
                lit1_b  = 8'h78;
              end else begin
                acc_d   = '0;
                phase_d = PhHex0;
              end
            end
            aced_pkg::ChBackslash: begin
              emit_en = 1'b1;
              emit_b  = aced_pkg::ChBackslash;
            end
            8'h27, 8'h22, 8'h3F: begin                            // quotes, question mark
              lit0_en = echo_q;
              lit0_b  = aced_pkg::ChBackslash;
              emit_en = 1'b1;
              emit_b  = b;
            end
            8'h63: begin                                          // c
              if (stopc_q) begin
                lit0_en = 1'b1;
                lit0_v  = 1'b0;
                lit0_s  = 1'b1;
                stop_d  = ~lst;
              end else if (!echo_q && !lst) begin
                phase_d = PhCtrl;
              end else begin
                lit0_en = ~drop_q;
                lit0_b  = aced_pkg::ChBackslash;
                emit_en = 1'b1;
                emit_b  = b;
              end
            end
            default: begin
              lit0_en = ~drop_q;
              lit0_b  = aced_pkg::ChBackslash;
              emit_en = 1'b1;
              emit_b  = b;
            end
          endcase
        end
        PhOct: begin
          if (b_is_oct && (dig_q != 2'd0)) begin
            acc_d = oct_acc;
            dig_d = dig_q - 2'd1;
            if ((dig_d == 2'd0) || lst) begin
              emit_en = 1'b1;
              emit_b  = acc_d;
              phase_d = PhIdle;
            end
          end else begin
            emit_en = 1'b1;
            emit_b  = acc_q;
            do_idle = 1'b1;
          end
        end
        PhHex0: begin
          if (quote_q && (b == 8'h7B)) begin                     // opening brace
            acc_d   = '0;
            phase_d = PhBrace;
            if (lst) begin
              emit_en = 1'b1;
              emit_b  = '0;
              phase_d = PhIdle;
            end
          end else if (b_is_hex) begin
            acc_d   = {4'b0, b_hex};
            phase_d = PhHex1;
            if (lst) begin
              emit_en = 1'b1;
              emit_b  = acc_d;
              phase_d = PhIdle;
            end
          end else begin
            lit0_en = 1'b1;
            lit0_b  = aced_pkg::ChBackslash;
            lit1_en = 1'b1;
            lit1_b  = 8'h78;
            do_idle = 1'b1;
          end
        end
        PhHex1: begin
          emit_en = 1'b1;
          if (b_is_hex) begin
            acc_d   = hex_acc;
            emit_b  = hex_acc;
            phase_d = PhIdle;
          end else begin
            emit_b  = acc_q;
            do_idle = 1'b1;
          end
        end
        PhBrace: begin
          if (b_is_hex) begin
            acc_d = hex_acc;
            if (lst) begin
              emit_en = 1'b1;
              emit_b  = hex_acc;
              phase_d = PhIdle;
            end
          end else if (b == 8'h7D) begin                          // closing brace
            emit_en = 1'b1;
            emit_b  = acc_q;
            phase_d = PhIdle;
          end else begin
            emit_en = 1'b1;
            emit_b  = acc_q;
            do_idle = 1'b1;
          end
        end
        PhCtrl: begin
          if (quote_q && (b == aced_pkg::ChBackslash) && !lst) begin
            phase_d = PhCtrlBs;
          end else begin
            emit_en = 1'b1;
            emit_b  = b & aced_pkg::CtrlMask;
            phase_d = PhIdle;
          end
        end
        PhCtrlBs: begin
          emit_en = 1'b1;
          emit_b  = aced_pkg::ChBackslash & aced_pkg::CtrlMask;
          phase_d = PhIdle;
          do_idle = (b != aced_pkg::ChBackslash);
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase
    end

    // A plain byte either opens an escape or passes through.
    if (do_idle) begin
      phase_d = ((b == aced_pkg::ChBackslash) && !lst) ? PhEsc : PhIdle;
    end

    // The end of a string returns the parser to its reset state.
    if (lst) begin
      phase_d = PhIdle;
      acc_d   = '0;
      dig_d   = '0;
      stop_d  = 1'b0;
    end
  end

  // Candidate results in output order.
  always_comb begin
    cand[0] = '{byte_out: lit0_b, byte_valid: lit0_v, stop_seen: lit0_s};
    cand[1] = '{byte_out: lit1_b, byte_valid: 1'b1, stop_seen: 1'b0};
    cand[2] = '{byte_out: aced_pkg::ChQuote, byte_valid: 1'b1, stop_seen: 1'b0};
    cand[3] = '{byte_out: emit_b & aced_pkg::ByteMask, byte_valid: 1'b1, stop_seen: 1'b0};
    cand[4] = '{byte_out: b, byte_valid: 1'b1, stop_seen: 1'b0};
    cand[5] = '{byte_out: 8'h00, byte_valid: 1'b0, stop_seen: 1'b0};
    cand_en[0] = lit0_en;
    cand_en[1] = lit1_en;
    cand_en[2] = emit_en & quote_q &
                 ((emit_b == aced_pkg::ChQuote) || (emit_b == aced_pkg::ChDel));
    cand_en[3] = emit_en;
    cand_en[4] = do_idle & ~((b == aced_pkg::ChBackslash) & ~lst);
    cand_en[5] = lst & ~(|cand_en[4:0]);
  end

  // Pack the enabled candidates into the bundle slots.
  always_comb begin
    bundle      = '0;
    bundle.last = lst;
    for (int i = 0; i < NumCand; i++) begin
      if (cand_en[i]) begin
        case (bundle.cnt)
          2'd0:    bundle.items[0] = cand[i];
          2'd1:    bundle.items[1] = cand[i];
          2'd2:    bundle.items[2] = cand[i];
          default: ;
        endcase
        if (bundle.cnt != 2'd3) begin
          bundle.cnt = bundle.cnt + 2'd1;
        end
      end
    end
  end

  assign push_o      = fire & (bundle.cnt != 2'd0);
  assign push_data_o = bundle;

  // Parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      acc_q   <= '0;
      dig_q   <= '0;
      stop_q  <= 1'b0;
    end else if (fire) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      dig_q   <= dig_d;
      stop_q  <= stop_d;
    end
  end

  // A stop is only ever raised from the escape phase, which returns to idle, and held there.
  a_stop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |-> (phase_q == PhIdle))
    else $error("stop flag set outside the idle phase");

  // The end of a string always leaves the parser clean.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && lst) |=> ((phase_q == PhIdle) && !stop_q && (dig_q == 2'd0)))
    else $error("parser state not cleared after final byte");

  // The final byte of a string always produces at least one result.
  a_last_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && lst) |-> push_o)
    else $error("final byte produced no result");

endmodule

// ----- hw/rtl/aced_queue.sv -----
// ----------------------------------------------------------------------------
// aced_queue
// Short first-in first-out queue of result bundles between the front end
// and the back end, so each side can stall on its own.
// ----------------------------------------------------------------------------
module aced_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  aced_pkg::bundle_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output aced_pkg::bundle_t head_o
);

  aced_pkg::bundle_t                mem_q [aced_pkg::QueueDepth];
  logic [aced_pkg::QPtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [aced_pkg::QCntW-1:0]       cnt_q;
  logic                             do_push, do_pop;

  assign full_o  = (cnt_q == aced_pkg::QCntW'(aced_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == aced_pkg::QPtrW'(aced_pkg::QueueDepth - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == aced_pkg::QPtrW'(aced_pkg::QueueDepth - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/aced_back.sv -----
// ----------------------------------------------------------------------------
// aced_back
// Back end: walks through the items of the bundle at the queue head, one
// per cycle while the receiver takes them, into the output register and
// marks the end of each run and of each string.
// ----------------------------------------------------------------------------
module aced_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  aced_pkg::bundle_t q_head_i,
  output logic              pop_o,
  aced_out_if.source        out_o
);

  logic [1:0]      idx_q, idx_d;
  logic            vld_q, vld_d;
  aced_pkg::item_t item_q;
  logic            run_end_q, last_out_q;

  logic            load;
  logic            fin;
  aced_pkg::item_t cur;

  assign cur  = q_head_i.items[idx_q];
  assign fin  = (idx_q == (q_head_i.cnt - 2'd1));
  assign load = ~q_empty_i & (~vld_q | out_o.ready);

  assign pop_o = load & fin;

  // Item index and output valid.
  always_comb begin
    idx_d = idx_q;
    vld_d = vld_q;
    if (load) begin
      idx_d = fin ? 2'd0 : idx_q + 2'd1;
      vld_d = 1'b1;
    end else if (out_o.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q     <= cur;
      run_end_q  <= fin;
      last_out_q <= fin & q_head_i.last;
    end
  end

  assign out_o.valid      = vld_q;
  assign out_o.byte_out   = item_q.byte_out;
  assign out_o.byte_valid = item_q.byte_valid;
  assign out_o.stop_seen  = item_q.stop_seen;
  assign out_o.run_end    = run_end_q;
  assign out_o.last_out   = last_out_q;

  // The item index never runs past the bundle at the head.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_empty_i |-> ((idx_q < q_head_i.cnt) && (q_head_i.cnt != 2'd0)))
    else $error("item index beyond bundle size");

  // A bundle leaves the queue only together with its last item.
  a_pop_on_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (vld_q && run_end_q && (idx_q == 2'd0)))
    else $error("bundle popped without closing its run");

  // A string end is always also the end of a run.
  a_last_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && last_out_q) |-> run_end_q)
    else $error("string end outside a run end");

endmodule

// ----- hw/rtl/ansi_c_escape_decoder_top.sv -----
// ----------------------------------------------------------------------------
// ansi_c_escape_decoder_top
// Streaming expander for backslash escape sequences in byte strings.
//
// Usage:
//   in_i carries the bytes of one string with last_in on its final byte;
//   out_o carries the expanded bytes, one result per transfer, with run_end
//   on the last result of each input byte and last_out on the last result
//   of the string. A result with byte_valid low is a marker only.
//   Configuration registers are written through cfg_we_i/cfg_idx_i/
//   cfg_wdata_i while no string is in flight.
// Timing:
//   The results of a byte pass through the bundle queue and then the output
//   register of the back end. One input byte is taken every cycle while each
//   byte yields at most one result and the receiver does not stall; a byte
//   with several results holds the output for one result per transfer, and
//   the two-entry bundle queue absorbs this before the input is held off.
// Reset:
//   rst_ni clears the configuration, the parser state and the queue.
//   When the receiver stalls, results wait in the output register and the
//   queue, and the input is held off once the queue is full.
// ----------------------------------------------------------------------------
module ansi_c_escape_decoder_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  aced_in_if.sink                       in_i,
  aced_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [aced_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic                          cfg_wdata_i
);

  logic              q_full, q_empty, push, pop;
  aced_pkg::bundle_t push_data, q_head;

  // Parser and configuration.
  aced_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Bundle queue.
  aced_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  // Result sequencer and output register.
  aced_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_head_i  (q_head),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

// ----- tb/ansi_c_escape_decoder_top_tb.sv -----
// ----------------------------------------------------------------------------
// ansi_c_escape_decoder_top_tb
// Self-checking bench for the backslash escape expander. A short table of
// directed strings is followed by random strings built from well-formed and
// malformed escapes with random content, over several register settings.
// Each byte transfer is expanded by an in-bench decoder and the result
// stream is compared item by item, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module ansi_c_escape_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumDirRows = 27;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned PhaseBytes = 60;
  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned ReportMax  = 10;

  // Decoder scan states.
  typedef enum logic [2:0] {
    SC_PLAIN, SC_ESC, SC_OCT, SC_HEX_FIRST, SC_HEX_SECOND, SC_BRACE, SC_CTRL, SC_CTRL_BS
  } scan_e;

  // Kinds of rows in the directed table.
  typedef enum logic [1:0] {ROW_BYTE, ROW_KNOWN, ROW_CFG} row_e;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       stop_seen;
    logic       run_end;
    logic       last_out;
  } result_t;

  // For ROW_CFG, data holds {stop_on_c, drop_unknown, quote_ctl, echo_mode}.
  typedef struct packed {
    row_e       kind;
    logic [7:0] data;
    logic       last;
    logic [7:0] known;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [aced_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic       cfg_wdata_i;

  aced_in_if  src_if ();
  aced_out_if res_if ();

  ansi_c_escape_decoder_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (src_if),
    .out_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // Decoder copy: register settings and scan state.
  logic       cfg_echo, cfg_quote, cfg_drop, cfg_stop_c;
  scan_e      scan_st;
  logic [7:0] code_acc;
  logic [1:0] oct_room;
  logic       halted;

  result_t    byte_results [$];
  result_t    decoded_q [$];
  int         fail_cnt = 0;
  int         quiet_cycles = 0;
  logic       src_steady = 1'b0;
  logic       snk_steady = 1'b0;

  // Directed strings; known rows carry their single result.
  dir_row_t dir_rows [NumDirRows] = '{
    '{ROW_KNOWN, 8'h00,                 1'b0, 8'h00},   // zero byte is plain data
    '{ROW_KNOWN, 8'hFF,                 1'b1, 8'hFF},
    '{ROW_BYTE,  aced_pkg::ChBackslash, 1'b0, 8'h00},
    '{ROW_BYTE,  "n",                   1'b0, 8'h00},
    '{ROW_BYTE,  aced_pkg::ChBackslash, 1'b0, 8'h00},
    '{ROW_BYTE,  "1",                   1'b0, 8'h00},
    '{ROW_BYTE,  "0",                   1'b0, 8'h00},
    '{ROW_BYTE,  "1",                   1'b0, 8'h00},
    '{ROW_KNOWN, "Z",                   1'b1, "Z"},
    '{ROW_BYTE,  aced_pkg::ChBackslash, 1'b0, 8'h00},
    '{ROW_BYTE,  "x",                   1'b0, 8'h00},
    '{ROW_BYTE,  "4",                   1'b0, 8'h00},
    '{ROW_BYTE,  "g",                   1'b1, 8'h00},   // hex ended by a non-digit
    '{ROW_BYTE,  aced_pkg::ChBackslash, 1'b0, 8'h00},
    '{ROW_BYTE,  "c",                   1'b0, 8'h00},
    '{ROW_BYTE,  "a",                   1'b0, 8'h00},
    // Lone trailing backslash.
    '{ROW_KNOWN, aced_pkg::ChBackslash, 1'b1, aced_pkg::ChBackslash},
    '{ROW_CFG,   8'h0A,                 1'b0, 8'h00},   // quote_ctl and stop_on_c
    '{ROW_BYTE,  aced_pkg::ChBackslash, 1'b0, 8'h00},
    '{ROW_BYTE,  "x",                   1'b0, 8'h00},
    '{ROW_BYTE,  "{",                   1'b0, 8'h00},
    '{ROW_BYTE,  "7",                   1'b0, 8'h00},
    '{ROW_BYTE,  "F",                   1'b0, 8'h00},
    '{ROW_BYTE,  "}",                   1'b0, 8'h00},
    '{ROW_BYTE,  aced_pkg::ChBackslash, 1'b0, 8'h00},
    '{ROW_BYTE,  "c",                   1'b0, 8'h00},
    '{ROW_BYTE,  "q",                   1'b1, 8'h00}
  };

  function automatic void add_result(input logic [7:0] v, input logic vld, input logic stp);
    result_t r;
    r = '{byte_out: v, byte_valid: vld, stop_seen: stp, run_end: 1'b0, last_out: 1'b0};
    if (byte_results.size() < aced_pkg::MaxResults) byte_results.push_back(r);
  endfunction

  // Escaped values 0x01 and 0x7F get a quote prefix in parser mode.
  function automatic void emit_code(input logic [7:0] v);
    if (cfg_quote && (v == aced_pkg::ChQuote || v == aced_pkg::ChDel))
      add_result(aced_pkg::ChQuote, 1'b1, 1'b0);
    add_result(v, 1'b1, 1'b0);
  endfunction

  function automatic void plain_byte(input logic [7:0] b, input logic l);
    scan_st = SC_PLAIN;
    if (b == aced_pkg::ChBackslash && !l) scan_st = SC_ESC;
    else add_result(b, 1'b1, 1'b0);
  endfunction

  function automatic void close_code();
    emit_code(code_acc);
    scan_st = SC_PLAIN;
  endfunction

  function automatic logic is_hex_digit(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic logic [7:0] hex_nibble(input logic [7:0] b);
    if (b >= "a" && b <= "f") return b - "a" + 8'd10;
    if (b >= "A" && b <= "F") return b - "A" + 8'd10;
    return b - "0";
  endfunction

  // Expands one source byte into byte_results and advances the scan state.
  function automatic void expand_byte(input logic [7:0] b, input logic l);
    byte_results.delete();
    if (halted) begin
      if (l) add_result(8'h00, 1'b0, 1'b1);
    end else begin
      case (scan_st)
        SC_ESC: begin
          scan_st = SC_PLAIN;
          case (b)
            "a": emit_code(8'h07);
            "v": emit_code(8'h0B);
            "b": emit_code(8'h08);
            "e", "E": emit_code(aced_pkg::ChEsc);
            "f": emit_code(8'h0C);
            "n": emit_code(8'h0A);
            "r": emit_code(8'h0D);
            "t": emit_code(8'h09);
            "1", "2", "3", "4", "5", "6", "7": begin
              if (cfg_echo) begin
                add_result(aced_pkg::ChBackslash, 1'b1, 1'b0);
                add_result(b, 1'b1, 1'b0);
              end else begin
                code_acc = b - "0";
                oct_room = 2'd2;
                scan_st = SC_OCT;
                if (l) close_code();
              end
            end
            "0": begin
              code_acc = 8'h00;
              oct_room = cfg_echo ? 2'd3 : 2'd2;
              scan_st = SC_OCT;
              if (l) close_code();
            end
            "x": begin
              if (l) begin
                add_result(aced_pkg::ChBackslash, 1'b1, 1'b0);
                add_result("x", 1'b1, 1'b0);
              end else begin
                code_acc = 8'h00;
                scan_st = SC_HEX_FIRST;
              end
            end
            aced_pkg::ChBackslash: emit_code(aced_pkg::ChBackslash);
            "'", "\"", "?": begin
              if (cfg_echo) add_result(aced_pkg::ChBackslash, 1'b1, 1'b0);
              emit_code(b);
            end
            "c": begin
              if (cfg_stop_c) begin
                add_result(8'h00, 1'b0, 1'b1);
                if (!l) halted = 1'b1;
              end else if (!cfg_echo && !l) begin
                scan_st = SC_CTRL;
              end else begin
                if (!cfg_drop) add_result(aced_pkg::ChBackslash, 1'b1, 1'b0);
                emit_code(b);
              end
            end
            default: begin
              if (!cfg_drop) add_result(aced_pkg::ChBackslash, 1'b1, 1'b0);
              emit_code(b);
            end
          endcase
        end
        SC_OCT: begin
          if (b >= "0" && b <= "7" && oct_room != 2'd0) begin
            code_acc = (code_acc << 3) + (b - "0");
            oct_room = oct_room - 2'd1;
            if (oct_room == 2'd0 || l) close_code();
          end else begin
            close_code();
            plain_byte(b, l);
          end
        end
        SC_HEX_FIRST: begin
          if (cfg_quote && b == "{") begin
            code_acc = 8'h00;
            scan_st = SC_BRACE;
            if (l) close_code();
          end else if (is_hex_digit(b)) begin
            code_acc = hex_nibble(b);
            scan_st = SC_HEX_SECOND;
            if (l) close_code();
          end else begin
            add_result(aced_pkg::ChBackslash, 1'b1, 1'b0);
            add_result("x", 1'b1, 1'b0);
            plain_byte(b, l);
          end
        end
        SC_HEX_SECOND: begin
          if (is_hex_digit(b)) begin
            code_acc = (code_acc << 4) + hex_nibble(b);
            close_code();
          end else begin
            close_code();
            plain_byte(b, l);
          end
        end
        SC_BRACE: begin
          if (is_hex_digit(b)) begin
            code_acc = (code_acc << 4) + hex_nibble(b);
            if (l) close_code();
          end else if (b == "}") begin
            close_code();
          end else begin
            close_code();
            plain_byte(b, l);
          end
        end
        SC_CTRL: begin
          if (cfg_quote && b == aced_pkg::ChBackslash && !l) begin
            scan_st = SC_CTRL_BS;
          end else begin
            emit_code(b & aced_pkg::CtrlMask);
            scan_st = SC_PLAIN;
          end
        end
        SC_CTRL_BS: begin
          emit_code(aced_pkg::ChBackslash & aced_pkg::CtrlMask);
          scan_st = SC_PLAIN;
          if (b != aced_pkg::ChBackslash) plain_byte(b, l);
        end
        default: plain_byte(b, l);
      endcase
    end

    // A final byte always ends with at least a marker result.
    if (l && byte_results.size() == 0) add_result(8'h00, 1'b0, 1'b0);
    foreach (byte_results[k]) begin
      byte_results[k].run_end  = (k == byte_results.size() - 1);
      byte_results[k].last_out = l && (k == byte_results.size() - 1);
    end
    if (l) begin
      scan_st  = SC_PLAIN;
      code_acc = 8'h00;
      oct_room = 2'd0;
      halted   = 1'b0;
    end
  endfunction

  function automatic void log_failure(input string what, input result_t want,
                                      input result_t got);
    fail_cnt++;
    if (fail_cnt <= ReportMax)
      $display("%0t %s: expected %h/%b/%b/%b/%b got %h/%b/%b/%b/%b", $time, what,
               want.byte_out, want.byte_valid, want.stop_seen, want.run_end, want.last_out,
               got.byte_out, got.byte_valid, got.stop_seen, got.run_end, got.last_out);
  endfunction

  // One byte transfer on the source channel, after a random gap.
  task automatic send_byte(input logic [7:0] b, input logic l, input logic has_known,
                           input logic [7:0] known);
    int unsigned gap;
    result_t     fixed;
    gap = src_steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      src_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    src_if.valid   <= 1'b1;
    src_if.byte_in <= b;
    src_if.last_in <= l;
    @(posedge clk_i);
    while (!src_if.ready) @(posedge clk_i);
    expand_byte(b, l);
    if (has_known) begin
      fixed = '{byte_out: known, byte_valid: 1'b1, stop_seen: 1'b0, run_end: 1'b1,
                last_out: l};
      decoded_q.push_back(fixed);
    end else begin
      foreach (byte_results[k]) decoded_q.push_back(byte_results[k]);
    end
  endtask

  // Holds the source off until every decoded result has been received.
  task automatic drain_results();
    src_if.valid <= 1'b0;
    @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
  endtask

  // Register writes happen only with the decoder empty and settled.
  task automatic write_regs(input logic [3:0] regs);
    drain_results();
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= aced_pkg::CfgEchoMode;
    cfg_wdata_i <= regs[0];
    @(posedge clk_i);
    cfg_idx_i   <= aced_pkg::CfgQuoteCtl;
    cfg_wdata_i <= regs[1];
    @(posedge clk_i);
    cfg_idx_i   <= aced_pkg::CfgDropUnknown;
    cfg_wdata_i <= regs[2];
    @(posedge clk_i);
    cfg_idx_i   <= aced_pkg::CfgStopOnC;
    cfg_wdata_i <= regs[3];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_echo   = regs[0];
    cfg_quote  = regs[1];
    cfg_drop   = regs[2];
    cfg_stop_c = regs[3];
  endtask

  // Result channel: random stalls, each transfer checked in order.
  initial begin : result_sink
    int unsigned stall;
    result_t     got;
    result_t     want;
    wait (rst_ni === 1'b1);
    forever begin
      stall = snk_steady ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (res_if.valid !== 1'b1) @(posedge clk_i);
      got = '{byte_out: res_if.byte_out, byte_valid: res_if.byte_valid,
              stop_seen: res_if.stop_seen, run_end: res_if.run_end,
              last_out: res_if.last_out};
      if (decoded_q.size() == 0) begin
        log_failure("result with nothing pending", '0, got);
      end else begin
        want = decoded_q.pop_front();
        if (got !== want) log_failure("result mismatch", want, got);
      end
    end
  end

  // Ends the run when neither channel has moved a transfer for too long.
  always @(posedge clk_i) begin : watchdog
    if ((src_if.valid && src_if.ready) || (res_if.valid && res_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("timeout after %0d cycles without a transfer", QuietLimit);
      $display("ansi_c_escape_decoder_top_tb NOT OK");
      $finish;
    end
  end

  // Reset, directed table, random phases, final verdict.
  initial begin : stimulus
    int          sent;
    int unsigned nd;
    logic [3:0]  regs;
    logic [7:0]  text_q [$];
    string       named_chars;
    string       hex_chars;
    string       quote_chars;

    named_chars = "abeEfnrtv";
    hex_chars   = "0123456789abcdefABCDEF";
    quote_chars = "'\"?\\";

    rst_ni         <= 1'b0;
    src_if.valid   <= 1'b0;
    src_if.byte_in <= 8'h00;
    src_if.last_in <= 1'b0;
    res_if.ready   <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= aced_pkg::CfgEchoMode;
    cfg_wdata_i    <= 1'b0;
    cfg_echo   = 1'b0;
    cfg_quote  = 1'b0;
    cfg_drop   = 1'b0;
    cfg_stop_c = 1'b0;
    scan_st    = SC_PLAIN;
    code_acc   = 8'h00;
    oct_room   = 2'd0;
    halted     = 1'b0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed strings at the reset settings, then in parser mode with stop.
    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG:   write_regs(dir_rows[i].data[3:0]);
        ROW_KNOWN: send_byte(dir_rows[i].data, dir_rows[i].last, 1'b1, dir_rows[i].known);
        default:   send_byte(dir_rows[i].data, dir_rows[i].last, 1'b0, 8'h00);
      endcase
    end

    // Random strings; the first two phases use all-clear and all-set registers.
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       regs = 4'b0000;
        1:       regs = 4'b1111;
        default: regs = 4'($urandom_range(0, 15));
      endcase
      src_steady = ($urandom_range(0, 3) == 0);
      snk_steady = ($urandom_range(0, 3) == 0);
      write_regs(regs);
      sent = 0;
      while (sent < PhaseBytes) begin
        if ($urandom_range(0, 31) == 0) drain_results();
        text_q.delete();
        repeat ($urandom_range(1, 5)) begin
          case ($urandom_range(0, 9))
            0, 1: text_q.push_back(8'($urandom_range(0, 255)));
            2: begin
              text_q.push_back(aced_pkg::ChBackslash);
              text_q.push_back(named_chars[$urandom_range(0, named_chars.len() - 1)]);
            end
            3: begin
              text_q.push_back(aced_pkg::ChBackslash);
              repeat ($urandom_range(1, 4)) text_q.push_back(8'("0" + $urandom_range(0, 7)));
            end
            4: begin
              text_q.push_back(aced_pkg::ChBackslash);
              text_q.push_back("x");
              repeat ($urandom_range(0, 3))
                text_q.push_back(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
            end
            5: begin
              text_q.push_back(aced_pkg::ChBackslash);
              text_q.push_back("x");
              text_q.push_back("{");
              nd = $urandom_range(0, 4);
              repeat (nd) text_q.push_back(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
              if ($urandom_range(0, 1) != 0) text_q.push_back("}");
            end
            6: begin
              text_q.push_back(aced_pkg::ChBackslash);
              text_q.push_back("c");
              if ($urandom_range(0, 1) != 0) text_q.push_back(aced_pkg::ChBackslash);
              text_q.push_back(8'($urandom_range(0, 255)));
            end
            7: begin
              text_q.push_back(aced_pkg::ChBackslash);
              text_q.push_back(quote_chars[$urandom_range(0, quote_chars.len() - 1)]);
            end
            8: begin
              text_q.push_back(aced_pkg::ChBackslash);
              text_q.push_back(8'($urandom_range(0, 255)));
            end
            default: text_q.push_back(aced_pkg::ChBackslash);
          endcase
        end
        foreach (text_q[k]) send_byte(text_q[k], k == text_q.size() - 1, 1'b0, 8'h00);
        sent += text_q.size();
      end
    end

    drain_results();
    repeat (16) @(posedge clk_i);
    if (fail_cnt == 0) $display("ansi_c_escape_decoder_top_tb OK");
    else $display("ansi_c_escape_decoder_top_tb NOT OK");
    $finish;
  end

endmodule
